FILE: hw/rtl/srt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ranking table package
// Shared widths, operation and status codes, and the structs that pass
// between the top level and the row of table cells.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int SCORE_W       = 32;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int RANK_W        = 3;
  localparam int POS_W         = 3;
  localparam int COUNT_OUT_W   = 4;
  localparam int DEPTH_DEFAULT = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANK_BEYOND = 2'd2;

  // Command broadcast to every cell.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [SCORE_W-1:0] value;
  } srt_cmd_t;

  // Flags a cell hands on to its right-hand neighbour and to the top level.
  typedef struct packed {
    logic hit;        // insert point lies at or before this cell
    logic seen;       // a matching entry lies at or before this cell
    logic first_ins;  // this cell is the insert point
    logic first_del;  // this cell holds the first matching entry
  } srt_link_t;

endpackage

FILE: hw/rtl/srt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ranking table cell
// Holds one score, compares it with the broadcast value and shifts in a
// neighbour's score when an entry is inserted before it or removed at or before it.
// ----------------------------------------------------------------------------
module srt_cell
  import srt_pkg::*;
(
  input  logic               clk,
  input  srt_cmd_t           cmd,
  input  logic               ins_occ,
  input  logic               del_occ,
  input  srt_link_t          left_link,
  input  logic [SCORE_W-1:0] left_score,
  input  logic [SCORE_W-1:0] right_score,
  output srt_link_t          link,
  output logic [SCORE_W-1:0] score
);

  logic [SCORE_W-1:0] score_r;
  logic [SCORE_W-1:0] score_nxt;
  logic               match;

  assign match          = del_occ && (score_r == cmd.value);
  assign link.hit       = !ins_occ || (score_r < cmd.value);
  assign link.seen      = left_link.seen || match;
  assign link.first_ins = link.hit && !left_link.hit;
  assign link.first_del = match && !left_link.seen;
  assign score          = score_r;

  always_comb begin
    score_nxt = score_r;
    if (cmd.ins) begin
      if (link.first_ins) begin
        score_nxt = cmd.value;
      end else if (left_link.hit) begin
        score_nxt = left_score;
      end
    end else if (cmd.del && link.seen) begin
      score_nxt = right_score;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
  end

endmodule

FILE: hw/rtl/sorted_ranking_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ranking table core
// Keeps up to DEPTH unsigned scores in descending order in a row of cells and
// answers insert, delete and read operations with one result word each.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall   in_operation, in_score, in_rank
//   out_      output     out_valid / out_stall out_status, out_position,
//                                              out_read_score, out_entry_count
//
// Each accepted word is fully processed in the cycle it is accepted: every
// cell compares its score with the broadcast value and shifts in parallel, so
// one word can be taken per cycle while the output is not stalled, and its result appears in the next cycle.
// The result sits in an output register; a new word is taken while that
// register is empty or being emptied in the same cycle.
// Reset (rst_n, synchronous, active low) empties the table and the output
// register; the cell contents themselves are not cleared, as the entry count
// alone decides which cells are live.
// ----------------------------------------------------------------------------
module sorted_ranking_table_core
  import srt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [SCORE_W-1:0]     in_score,
  input  logic [RANK_W-1:0]      in_rank,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    out_status,
  output logic [POS_W-1:0]       out_position,
  output logic [SCORE_W-1:0]     out_read_score,
  output logic [COUNT_OUT_W-1:0] out_entry_count
);

  // Count width holds DEPTH itself; index width addresses a cell.
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW  = (IW > POS_W) ? IW : POS_W;
  localparam int XW  = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
  localparam int RW  = (CW > RANK_W) ? CW : RANK_W;

  logic                   accept;
  srt_cmd_t               cmd;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic [CW-1:0]          n_ins;
  logic [DEPTH-1:0]       ins_occ;
  logic [DEPTH-1:0]       del_occ;
  srt_link_t              link      [DEPTH];
  logic [SCORE_W-1:0]     cell_score[DEPTH];
  logic [PW-1:0]          pos_ins;
  logic [PW-1:0]          pos_del;
  logic [RW-1:0]          rank_x;
  logic                   rank_ok;
  logic [SCORE_W-1:0]     rd_score;
  logic                   found;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [STATUS_W-1:0]    status_r;
  logic [STATUS_W-1:0]    status_nxt;
  logic [PW-1:0]          pos_r;
  logic [PW-1:0]          pos_nxt;
  logic [SCORE_W-1:0]     rd_r;
  logic [SCORE_W-1:0]     rd_nxt;
  logic [XW-1:0]          cnt_out_r;

  // The input waits only while an unread result is being held back.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // The state only moves on an accepted word.
  assign cmd.ins   = accept && (in_operation == OP_INSERT);
  assign cmd.del   = accept && (in_operation == OP_DELETE);
  assign cmd.value = in_score;

  // A full table drops its last entry first, so an insert searches among
  // one fewer live cells and always finds its place inside the row.
  assign n_ins = (count_r == CW'(DEPTH)) ? CW'(DEPTH - 1) : count_r;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      srt_link_t          l_link;
      logic [SCORE_W-1:0] l_score;
      logic [SCORE_W-1:0] r_score;

      assign ins_occ[g] = CW'(g) < n_ins;
      assign del_occ[g] = CW'(g) < count_r;

      if (g == 0) begin : g_head
        assign l_link  = '0;
        assign l_score = '0;
      end else begin : g_body
        assign l_link  = link[g-1];
        assign l_score = cell_score[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign r_score = cell_score[g];
      end else begin : g_mid
        assign r_score = cell_score[g+1];
      end

      srt_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .ins_occ     (ins_occ[g]),
        .del_occ     (del_occ[g]),
        .left_link   (l_link),
        .left_score  (l_score),
        .right_score (r_score),
        .link        (link[g]),
        .score       (cell_score[g])
      );
    end
  endgenerate

  // Exactly one cell at most flags itself as the insert point or as the first
  // match, so the position is the OR of the flagged indices.
  always_comb begin
    pos_ins = '0;
    pos_del = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (link[i].first_ins) begin
        pos_ins = pos_ins | PW'(i);
      end
      if (link[i].first_del) begin
        pos_del = pos_del | PW'(i);
      end
    end
  end

  assign found = link[DEPTH-1].seen;

  // A rank below the entry count always addresses a live cell.
  assign rank_x  = RW'(in_rank);
  assign rank_ok = rank_x < RW'(count_r);

  always_comb begin
    rd_score = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (RW'(i) == rank_x) begin
        rd_score = rd_score | cell_score[i];
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    pos_nxt    = '0;
    rd_nxt     = '0;
    case (in_operation)
      OP_INSERT: begin
        count_nxt = n_ins + CW'(1);
        pos_nxt   = pos_ins;
      end
      OP_DELETE: begin
        if (found) begin
          count_nxt = count_r - CW'(1);
          pos_nxt   = pos_del;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (rank_ok) begin
          pos_nxt = PW'(in_rank);
          rd_nxt  = rd_score;
        end else begin
          status_nxt = ST_RANK_BEYOND;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      pos_r     <= pos_nxt;
      rd_r      <= rd_nxt;
      cnt_out_r <= XW'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = pos_r[POS_W-1:0];
  assign out_read_score  = rd_r;
  assign out_entry_count = cnt_out_r[COUNT_OUT_W-1:0];

endmodule

FILE: hw/rtl/srt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ranking table checker
// Watches the ports of the core and flags results that break its rules.
// ----------------------------------------------------------------------------
module srt_checker
  import srt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [OP_W-1:0]        in_operation,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [STATUS_W-1:0]    out_status,
  input logic [POS_W-1:0]       out_position,
  input logic [SCORE_W-1:0]     out_read_score,
  input logic [COUNT_OUT_W-1:0] out_entry_count
);

  // The entry count port only shows the low bits of the count, so a table
  // deep enough to reach a multiple of that range can show zero when full.
  localparam bit COUNT_FITS = (DEPTH < (1 << COUNT_OUT_W));

  // Every accepted word produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word gave no result");

  // A held result keeps its status, read score and entry count.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_read_score) && $stable(out_entry_count)))
    else $error("held result changed");

  // Failed operations carry no position and no score.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOT_FOUND || out_status == ST_RANK_BEYOND))
      |-> (out_position == '0 && out_read_score == '0))
    else $error("failed operation carries data");

  // An accepted insert reports done and, where the count port is wide enough, shows at least one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == OP_INSERT)
      |=> ((!COUNT_FITS || out_entry_count != '0) && out_status == ST_DONE))
    else $error("insert left the table empty");

endmodule

bind sorted_ranking_table_core srt_checker #(.DEPTH(DEPTH)) u_srt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_position    (out_position),
  .out_read_score  (out_read_score),
  .out_entry_count (out_entry_count)
);
